// File: src/blwp_pkg.sv
// Shared types and constants of the weighted book-move picker.
package blwp_pkg;

  localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned SH1 = 30;
  localparam int unsigned SH2 = 27;
  localparam int unsigned SH3 = 31;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_LOADED = 3'd1,
    ST_NO_MATCH   = 3'd2,
    ST_ZERO_TOTAL = 3'd3,
    ST_FULL       = 3'd4,
    ST_ORDER      = 3'd5
  } status_t;

  typedef struct packed {
    logic    ld_in;
    logic    do_clear;
    logic    do_append;
    logic    bs_init;
    logic    rd_en;
    logic    rd_mid;
    logic    bs_step;
    logic    sum_init;
    logic    sum_step;
    logic    rng_add;
    logic    mul_load;
    logic    mul_sel;
    logic    mul_step;
    logic    div_init;
    logic    div_step;
    logic    walk_init;
    logic    walk_step;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic order;
    logic loaded;
    logic bs_open;
    logic lo_past;
    logic key_eq;
    logic idx_end;
    logic run_empty;
    logic total_zero;
    logic mul_done;
    logic div_done;
    logic walk_take;
  } dp_sts_t;

endpackage

// File: src/blwp_if.sv
// Valid/ready channel interfaces of the picker: request, result and seed write.
interface blwp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key;
  logic [15:0] move_code;
  logic [15:0] weight;
  modport source (output valid, op, key, move_code, weight, input ready);
  modport sink (input valid, op, key, move_code, weight, output ready);
endinterface

interface blwp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] chosen_move;
  logic [25:0] weight_total;
  modport source (output valid, status, chosen_move, weight_total, input ready);
  modport sink (input valid, status, chosen_move, weight_total, output ready);
endinterface

interface blwp_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: src/book_lookup_weighted_pick.sv
// Top level of the weighted book-move picker: controller plus datapath.
//  channel | dir | handshake            | payload
//  in_ch   | in  | in_ch.valid/ready    | op, key, move_code, weight
//  out_ch  | out | out_ch.valid/ready   | status, chosen_move, weight_total
//  cfg_ch  | in  | cfg_ch.valid/ready   | data (generator seed)
// One item at a time. Clear, append, unused op and a pick on an empty table go from decode straight to the result.
// A full pick runs a binary search for the first matching key, sums the run of matching entries,
// runs the generator (16-bit digit multiplier) and the bit-serial modulo, and walks the run
// entries. The entry memory's single read port sets the per-entry cost.
// Reset is synchronous and needs no clearing pass; a held result blocks new items.
module book_lookup_weighted_pick #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic      clk,
  input logic      rst_n,
  blwp_in_if.sink  in_ch,
  blwp_out_if.source out_ch,
  blwp_cfg_if.sink cfg_ch
);
  import blwp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  blwp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  blwp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_key           (in_ch.key),
    .in_move_code     (in_ch.move_code),
    .in_weight        (in_ch.weight),
    .cfg_valid        (cfg_ch.valid),
    .cfg_data         (cfg_ch.data),
    .out_status       (out_ch.status),
    .out_chosen_move  (out_ch.chosen_move),
    .out_weight_total (out_ch.weight_total)
  );

endmodule

// File: src/blwp_ctrl.sv
// Controller state machine of the picker: sequences search, sum, generator, modulo, walk.
module blwp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  blwp_pkg::dp_sts_t sts,
  output blwp_pkg::dp_cmd_t cmd,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready
);
  import blwp_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DECODE   = 15'b000000000000010,
    S_BS       = 15'b000000000000100,
    S_BS_CMP   = 15'b000000000001000,
    S_SUM_RD   = 15'b000000000010000,
    S_SUM_CHK  = 15'b000000000100000,
    S_SUM_END  = 15'b000000001000000,
    S_MIX1_LD  = 15'b000000010000000,
    S_MIX1     = 15'b000000100000000,
    S_MIX2_LD  = 15'b000001000000000,
    S_MIX2     = 15'b000010000000000,
    S_DIV      = 15'b000100000000000,
    S_WALK_RD  = 15'b001000000000000,
    S_WALK_CHK = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_OUT;
        unique case (sts.op)
          OP_CLEAR: cmd.do_clear = 1'b1;
          OP_APPEND: begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else if (sts.order) begin
              cmd.res_status = ST_ORDER;
            end else begin
              cmd.do_append = 1'b1;
            end
          end
          OP_PICK: begin
            if (!sts.loaded) begin
              cmd.res_status = ST_NOT_LOADED;
            end else begin
              cmd.res_load = 1'b0;
              cmd.bs_init  = 1'b1;
              state_nxt    = S_BS;
            end
          end
          default: ;
        endcase
      end
      S_BS: begin
        if (sts.bs_open) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_mid = 1'b1;
          state_nxt  = S_BS_CMP;
        end else if (sts.lo_past) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NO_MATCH;
          state_nxt      = S_OUT;
        end else begin
          cmd.sum_init = 1'b1;
          state_nxt    = S_SUM_RD;
        end
      end
      S_BS_CMP: begin
        cmd.bs_step = 1'b1;
        state_nxt   = S_BS;
      end
      S_SUM_RD: begin
        if (sts.idx_end) begin
          state_nxt = S_SUM_END;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SUM_CHK;
        end
      end
      S_SUM_CHK: begin
        if (sts.key_eq) begin
          cmd.sum_step = 1'b1;
          state_nxt    = S_SUM_RD;
        end else begin
          state_nxt = S_SUM_END;
        end
      end
      S_SUM_END: begin
        if (sts.run_empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NO_MATCH;
          state_nxt      = S_OUT;
        end else if (sts.total_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_ZERO_TOTAL;
          state_nxt      = S_OUT;
        end else begin
          cmd.rng_add = 1'b1;
          state_nxt   = S_MIX1_LD;
        end
      end
      S_MIX1_LD: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_MIX1;
      end
      S_MIX1: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = S_MIX2_LD;
      end
      S_MIX2_LD: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = 1'b1;
        state_nxt    = S_MIX2;
      end
      S_MIX2: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_take) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // modulo starts on the last multiply step; its dividend is the mixed word
    if (state_r == S_MIX2 && sts.mul_done) cmd.div_init = 1'b1;
  end

endmodule

// File: src/blwp_dp.sv
// Datapath of the picker: entry memory, search/sum registers, generator, multiplier, divider.
module blwp_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  blwp_pkg::dp_cmd_t cmd,
  output blwp_pkg::dp_sts_t sts,
  input  logic [1:0]        in_op,
  input  logic [63:0]       in_key,
  input  logic [15:0]       in_move_code,
  input  logic [15:0]       in_weight,
  input  logic              cfg_valid,
  input  logic [63:0]       cfg_data,
  output logic [2:0]        out_status,
  output logic [15:0]       out_chosen_move,
  output logic [25:0]       out_weight_total
);
  import blwp_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = CW + 16;

  logic [95:0] mem [TABLE_DEPTH];
  logic [95:0] rdata_r;
  logic [IW-1:0] rd_addr;

  op_t         op_r;
  logic [63:0] key_r;
  logic [15:0] mv_r, wt_r;
  logic [CW-1:0] count_r;
  logic        loaded_r;
  logic [63:0] last_key_r;
  logic [63:0] rng_r;

  logic [CW-1:0] lo_r, hi_r, mid;
  logic [CW-1:0] idx_r, start_r, last_r;
  logic [TW-1:0] total_r;

  logic [63:0] mul_a_r, mul_acc_r;
  logic [1:0]  mul_k_r;
  logic        mul_sel_r;
  logic [63:0] mul_c;
  logic [15:0] mul_d;
  logic [63:0] prod;
  logic [63:0] mixed;

  logic [63:0] dvd_r;
  logic [TW-1:0] rem_r;
  logic [5:0]  div_cnt_r;
  logic [TW:0] trial, diff;

  logic [63:0] rd_key;
  logic [15:0] rd_mv, rd_wt;

  status_t     st_r;
  logic [15:0] chosen_r;
  logic [TW-1:0] tot_out_r;

  assign {rd_key, rd_mv, rd_wt} = rdata_r;
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_addr = cmd.rd_mid ? mid[IW-1:0] : idx_r[IW-1:0];

  assign mul_c = mul_sel_r ? MIX_C2 : MIX_C1;
  assign mul_d = mul_c[{mul_k_r, 4'd0} +: 16];
  assign prod  = mul_a_r * 64'(mul_d);
  assign mixed = mul_acc_r ^ (mul_acc_r >> SH3);

  assign trial = {rem_r, dvd_r[63]};
  assign diff  = trial - {1'b0, total_r};

  always_comb begin
    sts.op         = op_r;
    sts.full       = (count_r == CW'(TABLE_DEPTH));
    sts.order      = (count_r != '0) && (key_r < last_key_r);
    sts.loaded     = loaded_r;
    sts.bs_open    = (lo_r < hi_r);
    sts.lo_past    = (lo_r >= count_r);
    sts.key_eq     = (rd_key == key_r);
    sts.idx_end    = (idx_r == count_r);
    sts.run_empty  = (idx_r == start_r);
    sts.total_zero = (total_r == '0);
    sts.mul_done   = (mul_k_r == 2'd3);
    sts.div_done   = (div_cnt_r == 6'd63);
    sts.walk_take  = ({2'b0, rem_r} < (TW + 2)'(rd_wt)) || (idx_r == last_r);
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.do_append) mem[count_r[IW-1:0]] <= {key_r, mv_r, wt_r};
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      loaded_r <= 1'b0;
      rng_r    <= '0;
    end else begin
      if (cmd.do_clear) begin
        count_r  <= '0;
        loaded_r <= 1'b0;
      end else if (cmd.do_append) begin
        count_r  <= count_r + 1'b1;
        loaded_r <= 1'b1;
      end
      if (cfg_valid) begin
        rng_r <= cfg_data;
      end else if (cmd.rng_add) begin
        rng_r <= rng_r + GAMMA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r     <= op_t'(in_op);
      key_r    <= in_key;
      mv_r     <= in_move_code;
      wt_r     <= in_weight;
      total_r  <= '0;
      chosen_r <= '0;
    end
    if (cmd.do_append) last_key_r <= key_r;
    if (cmd.bs_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end
    if (cmd.bs_step) begin
      if (rd_key < key_r) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
    if (cmd.sum_init) begin
      idx_r   <= lo_r;
      start_r <= lo_r;
    end
    if (cmd.sum_step) begin
      total_r <= total_r + TW'(rd_wt);
      last_r  <= idx_r;
      idx_r   <= idx_r + 1'b1;
    end
    if (cmd.mul_load) begin
      mul_a_r   <= cmd.mul_sel ? (mul_acc_r ^ (mul_acc_r >> SH2)) : (rng_r ^ (rng_r >> SH1));
      mul_sel_r <= cmd.mul_sel;
      mul_k_r   <= '0;
      mul_acc_r <= '0;
    end
    if (cmd.mul_step) begin
      mul_acc_r <= mul_acc_r + (prod << {mul_k_r, 4'd0});
      mul_k_r   <= mul_k_r + 1'b1;
    end
    if (cmd.div_init) begin
      // dividend taken in the next cycle, on the first modulo step, once the last partial product has landed
      div_cnt_r <= '0;
      rem_r     <= '0;
    end
    if (cmd.div_step) begin
      if (div_cnt_r == 6'd0) begin
        dvd_r <= mixed << 1;
        rem_r <= mixed[63] && (total_r == TW'(1)) ? '0 : TW'(mixed[63]);
      end else begin
        dvd_r <= dvd_r << 1;
        rem_r <= diff[TW] ? trial[TW-1:0] : diff[TW-1:0];
      end
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    // the last modulo step lands the remainder on the same edge
    if (cmd.walk_init) begin
      idx_r <= start_r;
    end
    if (cmd.walk_step) begin
      if (sts.walk_take) begin
        chosen_r <= rd_mv;
      end else begin
        rem_r <= rem_r - TW'(rd_wt);
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // output register; chosen move is loaded by the walk hit
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      st_r      <= cmd.res_status;
      tot_out_r <= (op_r == OP_PICK) ? total_r : '0;
    end
  end

  assign out_status       = st_r;
  assign out_chosen_move  = chosen_r;
  assign out_weight_total = 26'(tot_out_r);

endmodule

// File: src/blwp_chk.sv
// Port-level checker of the picker and its bind to the top level.
module blwp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] chosen_move,
  input logic [25:0] weight_total
);
  import blwp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(chosen_move)
      && $stable(weight_total))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("new item taken while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("controller did not leave idle after an item");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> chosen_move == 16'd0)
    else $error("move reported on a failed request");

  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_NOT_LOADED || status == ST_NO_MATCH || status == ST_FULL
      || status == ST_ORDER || status == ST_ZERO_TOTAL) |-> weight_total == 26'd0)
    else $error("weight total on a request without a weighted match");

endmodule

bind book_lookup_weighted_pick blwp_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .chosen_move  (out_ch.chosen_move),
  .weight_total (out_ch.weight_total)
);
